// ----- rtl/core/jtb_pkg.sv -----
// Shared constants, TAP state codes, frame type and next-state function
// for the JTAG TAP bus decoder. No dependencies.
`default_nettype none

package jtb_pkg;

  localparam int unsigned SHIFT_WIDTH = 64;
  localparam int unsigned CNT_W       = $clog2(SHIFT_WIDTH + 1);
  localparam int unsigned TIME_W      = 48;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned STATE_W     = 4;
  localparam int unsigned OUT_CNT_W   = 7;

  localparam logic [STATE_W-1:0] ST_RESET    = 4'd0;
  localparam logic [STATE_W-1:0] ST_IDLE     = 4'd1;
  localparam logic [STATE_W-1:0] ST_SEL_DR   = 4'd2;
  localparam logic [STATE_W-1:0] ST_CAP_DR   = 4'd3;
  localparam logic [STATE_W-1:0] ST_SHIFT_DR = 4'd4;
  localparam logic [STATE_W-1:0] ST_EX1_DR   = 4'd5;
  localparam logic [STATE_W-1:0] ST_PAUSE_DR = 4'd6;
  localparam logic [STATE_W-1:0] ST_EX2_DR   = 4'd7;
  localparam logic [STATE_W-1:0] ST_UPD_DR   = 4'd8;
  localparam logic [STATE_W-1:0] ST_SEL_IR   = 4'd9;
  localparam logic [STATE_W-1:0] ST_CAP_IR   = 4'd10;
  localparam logic [STATE_W-1:0] ST_SHIFT_IR = 4'd11;
  localparam logic [STATE_W-1:0] ST_EX1_IR   = 4'd12;
  localparam logic [STATE_W-1:0] ST_PAUSE_IR = 4'd13;
  localparam logic [STATE_W-1:0] ST_EX2_IR   = 4'd14;
  localparam logic [STATE_W-1:0] ST_UPD_IR   = 4'd15;

  typedef struct packed {
    logic [STATE_W-1:0]     state_left;
    logic [TIME_W-1:0]      start_time;
    logic [TIME_W-1:0]      end_time;
    logic [CNT_W-1:0]       bit_count;
    logic [SHIFT_WIDTH-1:0] tdi_word;
    logic [SHIFT_WIDTH-1:0] tdo_word;
  } frame_t;

  function automatic logic [STATE_W-1:0] tap_next(input logic [STATE_W-1:0] cur,
                                                  input logic tms);
    logic [STATE_W-1:0] nxt;
    case (cur)
      ST_RESET:    nxt = tms ? ST_RESET  : ST_IDLE;
      ST_IDLE:     nxt = tms ? ST_SEL_DR : ST_IDLE;
      ST_SEL_DR:   nxt = tms ? ST_SEL_IR : ST_CAP_DR;
      ST_CAP_DR:   nxt = tms ? ST_EX1_DR : ST_SHIFT_DR;
      ST_SHIFT_DR: nxt = tms ? ST_EX1_DR : ST_SHIFT_DR;
      ST_EX1_DR:   nxt = tms ? ST_UPD_DR : ST_PAUSE_DR;
      ST_PAUSE_DR: nxt = tms ? ST_EX2_DR : ST_PAUSE_DR;
      ST_EX2_DR:   nxt = tms ? ST_UPD_DR : ST_SHIFT_DR;
      ST_UPD_DR:   nxt = tms ? ST_SEL_DR : ST_IDLE;
      ST_SEL_IR:   nxt = tms ? ST_RESET  : ST_CAP_IR;
      ST_CAP_IR:   nxt = tms ? ST_EX1_IR : ST_SHIFT_IR;
      ST_SHIFT_IR: nxt = tms ? ST_EX1_IR : ST_SHIFT_IR;
      ST_EX1_IR:   nxt = tms ? ST_UPD_IR : ST_PAUSE_IR;
      ST_PAUSE_IR: nxt = tms ? ST_EX2_IR : ST_PAUSE_IR;
      ST_EX2_IR:   nxt = tms ? ST_UPD_IR : ST_SHIFT_IR;
      ST_UPD_IR:   nxt = tms ? ST_SEL_DR : ST_IDLE;
      default:     nxt = ST_RESET;
    endcase
    return nxt;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/jtb_capture.sv -----
// TAP state tracker and shift capture: holds the controller state, shift
// words, bit count and state start time, and builds the outgoing frame.
// Depends on jtb_pkg.
`default_nettype none

module jtb_capture (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         step_i,
  input  wire logic                         tms_bit_i,
  input  wire logic                         tdi_bit_i,
  input  wire logic                         tdo_bit_i,
  input  wire logic [jtb_pkg::TIME_W-1:0]   edge_time_i,
  output logic                              emit_o,
  output jtb_pkg::frame_t                   frame_o
);
  import jtb_pkg::*;

  logic [STATE_W-1:0]     state_q, state_d, nxt;
  logic [SHIFT_WIDTH-1:0] tdi_q, tdi_d, tdo_q, tdo_d;
  logic [SHIFT_WIDTH-1:0] tdi_sh, tdo_sh;
  logic [CNT_W-1:0]       cnt_q, cnt_d, cnt_sh;
  logic [TIME_W-1:0]      start_q, start_d;
  logic                   shifting;

  assign shifting = (state_q == ST_SHIFT_DR) || (state_q == ST_SHIFT_IR);
  assign nxt      = tap_next(state_q, tms_bit_i);
  assign emit_o   = (nxt != state_q);

  // Leaving edge of a shift state still takes its bit.
  always_comb begin
    if (shifting) begin
      tdi_sh = {tdi_q[SHIFT_WIDTH-2:0], tdi_bit_i};
      tdo_sh = {tdo_q[SHIFT_WIDTH-2:0], tdo_bit_i};
      cnt_sh = (cnt_q == CNT_W'(SHIFT_WIDTH)) ? cnt_q : cnt_q + CNT_W'(1);
    end else begin
      tdi_sh = tdi_q;
      tdo_sh = tdo_q;
      cnt_sh = cnt_q;
    end
  end

  always_comb begin
    frame_o.state_left = state_q;
    frame_o.start_time = start_q;
    frame_o.end_time   = edge_time_i;
    frame_o.bit_count  = cnt_sh;
    frame_o.tdi_word   = tdi_sh;
    frame_o.tdo_word   = tdo_sh;
  end

  always_comb begin
    state_d = state_q;
    tdi_d   = tdi_q;
    tdo_d   = tdo_q;
    cnt_d   = cnt_q;
    start_d = start_q;
    if (step_i) begin
      if (emit_o) begin
        state_d = nxt;
        tdi_d   = '0;
        tdo_d   = '0;
        cnt_d   = '0;
        start_d = edge_time_i;
      end else begin
        tdi_d = tdi_sh;
        tdo_d = tdo_sh;
        cnt_d = cnt_sh;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RESET;
      tdi_q   <= '0;
      tdo_q   <= '0;
      cnt_q   <= '0;
      start_q <= '0;
    end else begin
      state_q <= state_d;
      tdi_q   <= tdi_d;
      tdo_q   <= tdo_d;
      cnt_q   <= cnt_d;
      start_q <= start_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/jtb_word_rev.sv -----
// Optional bit reversal of a captured word over its bit count.
// Depends on jtb_pkg.
`default_nettype none

module jtb_word_rev (
  input  wire logic                            rev_en_i,
  input  wire logic [jtb_pkg::CNT_W-1:0]       count_i,
  input  wire logic [jtb_pkg::SHIFT_WIDTH-1:0] word_i,
  output logic      [jtb_pkg::SHIFT_WIDTH-1:0] word_o
);
  import jtb_pkg::*;

  logic [SHIFT_WIDTH-1:0] full_rev;
  logic [CNT_W-1:0]       rsh;

  always_comb begin
    for (int i = 0; i < SHIFT_WIDTH; i++) begin
      full_rev[i] = word_i[SHIFT_WIDTH-1-i];
    end
  end

  // Full reverse puts bit i at SHIFT_WIDTH-1-i; drop the unused top part.
  assign rsh    = CNT_W'(SHIFT_WIDTH) - count_i;
  assign word_o = rev_en_i ? (full_rev >> rsh) : word_i;

endmodule

`default_nettype wire

// ----- rtl/core/jtag_tap_bus_decoder.sv -----
// Passive JTAG monitor: input register, TAP tracker with shift capture,
// word reversal and result register. Depends on jtb_pkg, jtb_capture, jtb_word_rev.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o): one transfer per rising TCK edge,
//   carrying the sampled TMS, TDI, TDO and a 48-bit timestamp.
//   Output channel (out_valid_o/out_ready_i): one frame per TAP state change,
//   describing the state left, its start and end times, the shifted bit count
//   and the captured TDI/TDO words. Edges that keep the state emit nothing.
//   cfg_we_i/cfg_wdata_i write the MSB-first flag; write only while idle.
//   Pipeline: an accepted edge waits in the input register, then steps the
//   TAP tracker and its frame goes into the result register (two register stages).
//   Throughput: one edge per clock while no frame stalls the output, as the
//   TAP state register and the result register update on each step.
//   Stall: while a frame waits, edges that cause no frame keep flowing; an
//   edge that causes one waits in the input register and in_ready_o drops
//   once that register is also full.
//   Reset: the controller returns to Test-Logic-Reset, capture clears,
//   start time is zero, MSB-first order is off, both channels are empty.
`default_nettype none

module jtag_tap_bus_decoder (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic                              cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              tms_bit_i,
  input  wire logic                              tdi_bit_i,
  input  wire logic                              tdo_bit_i,
  input  wire logic [jtb_pkg::TIME_W-1:0]        edge_time_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic      [jtb_pkg::STATE_W-1:0]       state_left_o,
  output logic      [jtb_pkg::TIME_W-1:0]        start_time_o,
  output logic      [jtb_pkg::TIME_W-1:0]        end_time_o,
  output logic      [jtb_pkg::OUT_CNT_W-1:0]     bit_count_o,
  output logic      [jtb_pkg::WORD_W-1:0]        tdi_word_o,
  output logic      [jtb_pkg::WORD_W-1:0]        tdo_word_o
);
  import jtb_pkg::*;

  logic                   msb_first_q;
  logic                   in_vld_q;
  logic                   tms_q, tdi_q, tdo_q;
  logic [TIME_W-1:0]      time_q;
  logic                   out_vld_q, out_vld_d;
  frame_t                 res_q, res_d;
  frame_t                 frame;
  logic                   emit, step, in_xfer;
  logic [SHIFT_WIDTH-1:0] tdi_rev, tdo_rev;

  // Advance the held edge unless its frame has nowhere to go.
  assign step       = in_vld_q && (!emit || !out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || step;
  assign in_xfer    = in_valid_i && in_ready_o;

  jtb_capture u_capture (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .tms_bit_i   (tms_q),
    .tdi_bit_i   (tdi_q),
    .tdo_bit_i   (tdo_q),
    .edge_time_i (time_q),
    .emit_o      (emit),
    .frame_o     (frame)
  );

  jtb_word_rev u_tdi_rev (
    .rev_en_i (msb_first_q),
    .count_i  (frame.bit_count),
    .word_i   (frame.tdi_word),
    .word_o   (tdi_rev)
  );

  jtb_word_rev u_tdo_rev (
    .rev_en_i (msb_first_q),
    .count_i  (frame.bit_count),
    .word_i   (frame.tdo_word),
    .word_o   (tdo_rev)
  );

  always_comb begin
    res_d          = frame;
    res_d.tdi_word = tdi_rev;
    res_d.tdo_word = tdo_rev;
    out_vld_d      = out_vld_q && !out_ready_i;
    if (step && emit) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msb_first_q <= 1'b0;
      in_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        msb_first_q <= cfg_wdata_i;
      end
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      tms_q  <= tms_bit_i;
      tdi_q  <= tdi_bit_i;
      tdo_q  <= tdo_bit_i;
      time_q <= edge_time_i;
    end
    if (step && emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign state_left_o = res_q.state_left;
  assign start_time_o = res_q.start_time;
  assign end_time_o   = res_q.end_time;
  assign bit_count_o  = OUT_CNT_W'(res_q.bit_count);
  assign tdi_word_o   = WORD_W'(res_q.tdi_word);
  assign tdo_word_o   = WORD_W'(res_q.tdo_word);

endmodule

`default_nettype wire

// ----- rtl/core/jtb_checker.sv -----
// Port-level checks for jtag_tap_bus_decoder and the bind that attaches
// them. Depends on jtb_pkg and jtag_tap_bus_decoder.
`default_nettype none

module jtb_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              out_valid_o,
  input wire logic                              out_ready_i,
  input wire logic [jtb_pkg::STATE_W-1:0]       state_left_o,
  input wire logic [jtb_pkg::TIME_W-1:0]        end_time_o,
  input wire logic [jtb_pkg::OUT_CNT_W-1:0]     bit_count_o,
  input wire logic [jtb_pkg::WORD_W-1:0]        tdi_word_o,
  input wire logic [jtb_pkg::WORD_W-1:0]        tdo_word_o
);
  import jtb_pkg::*;

  logic shift_left;
  assign shift_left = (state_left_o == ST_SHIFT_DR) || (state_left_o == ST_SHIFT_IR);

  // Hold a stalled frame.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(state_left_o)
      && $stable(end_time_o) && $stable(tdi_word_o) && $stable(bit_count_o))
    else $error("frame changed while stalled");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> bit_count_o <= OUT_CNT_W'(SHIFT_WIDTH))
    else $error("bit count above shift width");

  a_no_shift_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !shift_left |-> bit_count_o == '0 && tdi_word_o == '0
      && tdo_word_o == '0)
    else $error("non-shift frame carries data");

  a_shift_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && shift_left |-> bit_count_o != '0)
    else $error("shift frame with no bits");

endmodule

bind jtag_tap_bus_decoder jtb_checker u_jtb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .state_left_o (state_left_o),
  .end_time_o   (end_time_o),
  .bit_count_o  (bit_count_o),
  .tdi_word_o   (tdi_word_o),
  .tdo_word_o   (tdo_word_o)
);

`default_nettype wire

// ----- sim/jtb_frame_checker.sv -----
`timescale 1ns / 1ps
// Frame checker for the JTAG TAP bus decoder: follows the TAP controller on
// every accepted edge, predicts the frames and compares them at the output.
// Depends on jtb_pkg.

module jtb_frame_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_wdata_i,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic                            tms_bit_i,
  input  logic                            tdi_bit_i,
  input  logic                            tdo_bit_i,
  input  logic [jtb_pkg::TIME_W-1:0]      edge_time_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [jtb_pkg::STATE_W-1:0]     state_left_i,
  input  logic [jtb_pkg::TIME_W-1:0]      start_time_i,
  input  logic [jtb_pkg::TIME_W-1:0]      end_time_i,
  input  logic [jtb_pkg::OUT_CNT_W-1:0]   bit_count_i,
  input  logic [jtb_pkg::WORD_W-1:0]      tdi_word_i,
  input  logic [jtb_pkg::WORD_W-1:0]      tdo_word_i,
  output int unsigned                     fault_count_o,
  output int unsigned                     frames_due_o
);
  import jtb_pkg::*;

  localparam int unsigned REPORT_LIMIT = 10;

  frame_t             frames_due[$];
  logic [STATE_W-1:0] tap_now;
  logic [WORD_W-1:0]  tdi_cap;
  logic [WORD_W-1:0]  tdo_cap;
  logic [CNT_W-1:0]   cap_count;
  logic [TIME_W-1:0]  state_began;
  logic               msb_first;
  int unsigned        faults;

  function automatic logic [STATE_W-1:0] tap_follow(input logic [STATE_W-1:0] cur,
                                                    input logic tms);
    logic [STATE_W-1:0] nxt;
    if (tms) begin
      case (cur)
        ST_RESET, ST_SEL_IR:            nxt = ST_RESET;
        ST_IDLE, ST_UPD_DR, ST_UPD_IR:  nxt = ST_SEL_DR;
        ST_SEL_DR:                      nxt = ST_SEL_IR;
        ST_CAP_DR, ST_SHIFT_DR:         nxt = ST_EX1_DR;
        ST_EX1_DR, ST_EX2_DR:           nxt = ST_UPD_DR;
        ST_PAUSE_DR:                    nxt = ST_EX2_DR;
        ST_CAP_IR, ST_SHIFT_IR:         nxt = ST_EX1_IR;
        ST_EX1_IR, ST_EX2_IR:           nxt = ST_UPD_IR;
        default:                        nxt = ST_EX2_IR;
      endcase
    end else begin
      case (cur)
        ST_RESET, ST_IDLE, ST_UPD_DR, ST_UPD_IR: nxt = ST_IDLE;
        ST_SEL_DR:                               nxt = ST_CAP_DR;
        ST_CAP_DR, ST_SHIFT_DR, ST_EX2_DR:       nxt = ST_SHIFT_DR;
        ST_EX1_DR, ST_PAUSE_DR:                  nxt = ST_PAUSE_DR;
        ST_SEL_IR:                               nxt = ST_CAP_IR;
        ST_CAP_IR, ST_SHIFT_IR, ST_EX2_IR:       nxt = ST_SHIFT_IR;
        default:                                 nxt = ST_PAUSE_IR;
      endcase
    end
    return nxt;
  endfunction

  // bit i of the low n bits lands at n-1-i, everything above n is dropped
  function automatic logic [WORD_W-1:0] mirror_low(input logic [WORD_W-1:0] w,
                                                   input logic [CNT_W-1:0] n);
    logic [WORD_W-1:0] r;
    r = '0;
    for (int i = 0; i < n; i++) r[n - 1 - i] = w[i];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    frame_t             due;
    frame_t             seen;
    logic [STATE_W-1:0] nxt;
    if (!rst_ni) begin
      frames_due.delete();
      tap_now       = ST_RESET;
      tdi_cap       = '0;
      tdo_cap       = '0;
      cap_count     = '0;
      state_began   = '0;
      msb_first     = 1'b0;
      faults        = 0;
      fault_count_o <= 0;
      frames_due_o  <= 0;
    end else begin
      if (cfg_we_i) msb_first = cfg_wdata_i;

      // compare before predicting: a frame never comes from the edge of this cycle
      if (out_valid_i && out_ready_i) begin
        seen = {state_left_i, start_time_i, end_time_i, bit_count_i, tdi_word_i, tdo_word_i};
        if (frames_due.size() == 0) begin
          faults++;
          if (faults <= REPORT_LIMIT)
            $display("[%0t] frame with nothing pending: state %0d end %h", $time,
                     seen.state_left, seen.end_time);
        end else begin
          due = frames_due.pop_front();
          if (seen !== due) begin
            faults++;
            if (faults <= REPORT_LIMIT) begin
              $display("[%0t] frame mismatch", $time);
              $display("  expected: state %0d start %h end %h bits %0d tdi %h tdo %h",
                       due.state_left, due.start_time, due.end_time, due.bit_count,
                       due.tdi_word, due.tdo_word);
              $display("  actual:   state %0d start %h end %h bits %0d tdi %h tdo %h",
                       seen.state_left, seen.start_time, seen.end_time, seen.bit_count,
                       seen.tdi_word, seen.tdo_word);
            end
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        // the edge that leaves a shift state still shifts its bit in
        if (tap_now == ST_SHIFT_DR || tap_now == ST_SHIFT_IR) begin
          tdi_cap = {tdi_cap[WORD_W-2:0], tdi_bit_i};
          tdo_cap = {tdo_cap[WORD_W-2:0], tdo_bit_i};
          if (cap_count < SHIFT_WIDTH) cap_count = cap_count + 1'b1;
        end
        nxt = tap_follow(tap_now, tms_bit_i);
        if (nxt != tap_now) begin
          due.state_left = tap_now;
          due.start_time = state_began;
          due.end_time   = edge_time_i;
          due.bit_count  = cap_count;
          due.tdi_word   = msb_first ? mirror_low(tdi_cap, cap_count) : tdi_cap;
          due.tdo_word   = msb_first ? mirror_low(tdo_cap, cap_count) : tdo_cap;
          frames_due.push_back(due);
          state_began = edge_time_i;
          tap_now     = nxt;
          tdi_cap     = '0;
          tdo_cap     = '0;
          cap_count   = '0;
        end
      end

      fault_count_o <= faults;
      frames_due_o  <= frames_due.size();
    end
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// Simulation top for the JTAG TAP bus decoder: clock, reset, TCK edge traffic,
// receiver stalls and verdict. Depends on jtb_pkg, jtb_frame_checker and the RTL.

module tb;
  import jtb_pkg::*;

  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_EDGES   = 125;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  // reset, idle, DR scan with pause and resume, IR scan with pause, back to reset
  localparam bit [0:25] WALK_TMS = 26'b10100001010111100010110111;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic                  cfg_wdata = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic                  tms_bit   = 1'b0;
  logic                  tdi_bit   = 1'b0;
  logic                  tdo_bit   = 1'b0;
  logic [TIME_W-1:0]     edge_time = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [STATE_W-1:0]    state_left;
  logic [TIME_W-1:0]     start_time;
  logic [TIME_W-1:0]     end_time;
  logic [OUT_CNT_W-1:0]  bit_count;
  logic [WORD_W-1:0]     tdi_word;
  logic [WORD_W-1:0]     tdo_word;

  int unsigned           fault_count;
  int unsigned           frames_due;
  int unsigned           edges_sent  = 0;
  int unsigned           frames_seen = 0;
  int unsigned           full_frames = 0;
  int unsigned           idle_cycles = 0;
  int unsigned           burst_left  = 0;
  bit                    steady      = 1'b0;
  logic [TIME_W-1:0]     stamp       = '0;

  jtag_tap_bus_decoder u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .tms_bit_i    (tms_bit),
    .tdi_bit_i    (tdi_bit),
    .tdo_bit_i    (tdo_bit),
    .edge_time_i  (edge_time),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .state_left_o (state_left),
    .start_time_o (start_time),
    .end_time_o   (end_time),
    .bit_count_o  (bit_count),
    .tdi_word_o   (tdi_word),
    .tdo_word_o   (tdo_word)
  );

  jtb_frame_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .tms_bit_i     (tms_bit),
    .tdi_bit_i     (tdi_bit),
    .tdo_bit_i     (tdo_bit),
    .edge_time_i   (edge_time),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .state_left_i  (state_left),
    .start_time_i  (start_time),
    .end_time_i    (end_time),
    .bit_count_i   (bit_count),
    .tdi_word_i    (tdi_word),
    .tdo_word_i    (tdo_word),
    .fault_count_o (fault_count),
    .frames_due_o  (frames_due)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // watchdog: any transfer on either channel restarts the count
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("no transfer for %0d cycles, giving up", idle_cycles);
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_valid && out_ready) begin
        frames_seen <= frames_seen + 1;
        if (bit_count == SHIFT_WIDTH) full_frames <= full_frames + 1;
      end
    end
  end

  // receiver: always ready, random drops, or stall runs, switching now and then
  initial begin : rx_pace
    int unsigned run_left;
    int unsigned stall_left;
    int unsigned mode;
    run_left   = 0;
    stall_left = 0;
    mode       = 0;
    forever begin
      @(posedge clk_i);
      if (run_left == 0) begin
        mode     = $urandom_range(0, 2);
        run_left = $urandom_range(16, 160);
      end
      run_left--;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: begin
          if (stall_left != 0) begin
            stall_left--;
            out_ready <= 1'b0;
          end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 12);
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // present one edge at the current stamp, hold until transfer, then pace the burst
  task automatic tck_edge(input logic tms);
    in_valid  <= 1'b1;
    tms_bit   <= tms;
    tdi_bit   <= $urandom_range(0, 1);
    tdo_bit   <= $urandom_range(0, 1);
    edge_time <= stamp;
    do @(posedge clk_i); while (!in_ready);
    edges_sent++;
    if (!steady) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        burst_left = $urandom_range(1, 40);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic step_tms(input logic tms);
    if ($urandom_range(0, 49) == 0) stamp = TIME_W'({$urandom, $urandom});
    else stamp = stamp + $urandom_range(1, 5000);
    tck_edge(tms);
  endtask

  // hold the sender until every frame is out, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (frames_due != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_order(input logic msb);
    cfg_we    <= 1'b1;
    cfg_wdata <= msb;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // five TMS highs reach Test-Logic-Reset from anywhere, one low drops into idle
  task automatic home();
    repeat (5) step_tms(1'b1);
    step_tms(1'b0);
  endtask

  function automatic int unsigned shift_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 16);
    if (roll < 90) return $urandom_range(17, 63);
    if (roll < 98) return $urandom_range(64, 72);
    return $urandom_range(100, 200);
  endfunction

  // one DR or IR scan from idle back to idle, optionally through pause and resume
  task automatic scan(input bit to_ir, input int unsigned nbits);
    int unsigned more;
    step_tms(1'b1);
    if (to_ir) step_tms(1'b1);
    step_tms(1'b0);
    if (nbits != 0) begin
      step_tms(1'b0);
      repeat (nbits - 1) step_tms(1'b0);
    end
    step_tms(1'b1);
    if ($urandom_range(0, 2) == 0) begin
      step_tms(1'b0);
      repeat ($urandom_range(0, 3)) step_tms(1'b0);
      step_tms(1'b1);
      if ($urandom_range(0, 1) == 0) begin
        more = shift_len();
        step_tms(1'b0);
        repeat (more - 1) step_tms(1'b0);
        step_tms(1'b1);
      end
    end
    step_tms(1'b1);
    step_tms(1'b0);
    repeat ($urandom_range(0, 3)) step_tms(1'b0);
  endtask

  // random TMS from idle, often abandoning a scan halfway
  task automatic scramble();
    repeat ($urandom_range(1, 12)) step_tms($urandom_range(0, 1));
    home();
  endtask

  initial begin : stimulus
    int unsigned phase_start;
    int unsigned roll;
    burst_left = $urandom_range(1, 40);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_order(1'b1);
    for (int k = 0; k < 26; k++) begin
      if (k < 2) begin
        stamp = (k == 0) ? '0 : TIME_MAX;
        tck_edge(WALK_TMS[k]);
      end else begin
        step_tms(WALK_TMS[k]);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      set_order(p % 2 == 1);
      steady = ($urandom_range(0, 3) == 0);
      home();
      phase_start = edges_sent;
      while (edges_sent - phase_start < PHASE_EDGES) begin
        roll = $urandom_range(0, 99);
        if (roll < 75)
          scan($urandom_range(0, 1), ($urandom_range(0, 9) == 0) ? 0 : shift_len());
        else if (roll < 88)
          repeat ($urandom_range(1, 6)) step_tms(1'b0);
        else
          scramble();
        if ($urandom_range(0, 14) == 0) settle();
      end
    end

    settle();
    $display("run covered %0d TCK edges and %0d frames, %0d of them with a full capture",
             edges_sent, frames_seen, full_frames);
    $display("both bit orders over %0d phases, with sender gaps and receiver stalls",
             PHASES);
    if (fault_count == 0 && frames_due == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/jtb_pkg.sv
rtl/core/jtb_capture.sv
rtl/core/jtb_word_rev.sv
rtl/core/jtag_tap_bus_decoder.sv
rtl/core/jtb_checker.sv
sim/jtb_frame_checker.sv
sim/tb.sv
